// File: rtl/awbb_pkg.sv
// ----------------------------------------------------------------------------
// awbb_pkg: shared types and constants for the alpha-weighted row blur
// Payload structs, sequencer states, divider request/response and sizing.
// ----------------------------------------------------------------------------
package awbb_pkg;

  localparam int MAX_WINDOW = 257;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int N_W        = 9;
  // largest window the 9-bit size register can select
  localparam int N_LIMIT    = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
  localparam int ATOT_W     = $clog2(N_LIMIT * 255 + 1);
  localparam int CTOT_W     = $clog2(N_LIMIT * 65025 + 1);
  localparam int Q_W        = 8;
  localparam int QCNT_W     = $clog2(Q_W);
  localparam int DIV_W      = ATOT_W + Q_W;
  localparam int PIX_W      = 32;

  typedef struct packed {
    logic       row_start;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pix_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_SUB
  } state_t;

  // channel step codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [ATOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

  // zero selects one, anything past the store depth saturates
  function automatic logic [N_W-1:0] eff_size(input logic [N_W-1:0] v);
    logic [N_W-1:0] n;
    n = v;
    if (v == '0) begin
      n = N_W'(1);
    end else if (v > N_W'(N_LIMIT)) begin
      n = N_W'(N_LIMIT);
    end
    return n;
  endfunction

endpackage

// File: rtl/awbb_ram.sv
// ----------------------------------------------------------------------------
// awbb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module awbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/awbb_div.sv
// ----------------------------------------------------------------------------
// awbb_div: iterative restoring divider, one quotient bit per cycle
// Quotient is known to fit in Q_W bits, so only Q_W steps are run.
// ----------------------------------------------------------------------------
module awbb_div import awbb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  sh_r, sh_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign diff = {1'b0, rem_r} - {1'b0, sh_r};
  assign ge   = ~diff[DIV_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QCNT_W'(Q_W - 1);
      rem_nxt  = req.dividend;
      sh_nxt   = DIV_W'({req.divisor, {(Q_W - 1){1'b0}}});
      q_nxt    = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = diff[DIV_W-1:0];
      end
      q_nxt   = {q_r[Q_W-2:0], ge};
      sh_nxt  = sh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// File: rtl/alpha_weighted_box_blur_row.sv
// ----------------------------------------------------------------------------
// alpha_weighted_box_blur_row: sliding box blur over one ARGB row
// Running alpha and alpha-weighted colour sums over the last N pixels,
// one shared multiplier for the sums and one shared divider for results.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+-----------------
//   input    | in_valid in_ready in_data      | valid/ready
//   result   | out_valid out_ready out_data   | valid/ready
//   config   | cfg_valid cfg_ready cfg_data   | valid/ready
//
// Pixel without result: accept, three multiply-accumulates, then a check.
// Pixel with result: four quotients through the 8-step divider, then the
// result register is loaded once it is free, then four steps retire the
// oldest pixel. A zero alpha sum skips the divider and writes zero results.
// Reset: synchronous; window cleared, size 1. Window store needs no clearing.
// The result register lets the next pixel enter while a result waits;
// the sequencer holds before its own result write until the slot frees.
// ----------------------------------------------------------------------------
module alpha_weighted_box_blur_row import awbb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pix_in_t        in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pix_out_t       out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [N_W-1:0] cfg_data
);

  localparam int OW = ((ADDR_W > N_W) ? ADDR_W : N_W) + 1;

  state_t             state_r, state_nxt;
  logic [1:0]         ch_r, ch_nxt;
  logic [N_W-1:0]     n_r, n_nxt;
  logic [N_W-1:0]     fill_r, fill_nxt;
  logic [ADDR_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]  slot_r, slot_nxt;
  pix_in_t            pix_r, pix_nxt;
  logic [ATOT_W-1:0]  alpha_tot_r, alpha_tot_nxt;
  logic [CTOT_W-1:0]  red_tot_r, red_tot_nxt;
  logic [CTOT_W-1:0]  green_tot_r, green_tot_nxt;
  logic [CTOT_W-1:0]  blue_tot_r, blue_tot_nxt;
  pix_out_t           res_r, res_nxt;
  pix_out_t           out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               cfg_fire, in_fire;
  logic [ADDR_W-1:0]  slot_in;
  logic               ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [PIX_W-1:0]   ram_rd_data;
  logic [7:0]         old_a, old_c, new_c, mac_a, mac_c;
  logic [15:0]        prod;
  logic [CTOT_W-1:0]  tot_sel, mac_sum, mac_diff;
  logic [OW-1:0]      slot_e, nm1_e, oldest_e;
  logic [N_W-1:0]     nm1;
  logic               do_result;
  logic [Q_W-1:0]     res_val;
  logic               res_we;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign slot_in   = in_data.row_start ? '0 : ptr_r;
  assign do_result = (fill_r >= n_r);

  awbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot_in),
    .wr_data ({in_data.alpha, in_data.red, in_data.green, in_data.blue}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  awbb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // shared multiply-accumulate operands, selected by channel step
  assign old_a = ram_rd_data[31:24];

  always_comb begin
    case (ch_r)
      CH_RED: begin
        old_c   = ram_rd_data[23:16];
        new_c   = pix_r.red;
        tot_sel = red_tot_r;
      end
      CH_GREEN: begin
        old_c   = ram_rd_data[15:8];
        new_c   = pix_r.green;
        tot_sel = green_tot_r;
      end
      default: begin
        old_c   = ram_rd_data[7:0];
        new_c   = pix_r.blue;
        tot_sel = blue_tot_r;
      end
    endcase
  end

  assign mac_a    = (state_r == ST_SUB) ? old_a : pix_r.alpha;
  assign mac_c    = (state_r == ST_SUB) ? old_c : new_c;
  assign prod     = mac_c * mac_a;
  assign mac_sum  = tot_sel + CTOT_W'(prod);
  assign mac_diff = tot_sel - CTOT_W'(prod);

  // oldest slot = slot - (n-1), modulo store depth
  assign nm1      = n_r - 1'b1;
  assign slot_e   = OW'(slot_r);
  assign nm1_e    = OW'(nm1);
  assign oldest_e = (slot_e >= nm1_e) ? (slot_e - nm1_e)
                                      : (slot_e + OW'(MAX_WINDOW) - nm1_e);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (ch_r == CH_BLUE) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = do_result ? ST_DIV_GO : ST_IDLE;
      end
      ST_DIV_GO: begin
        if (alpha_tot_r != '0) begin
          state_nxt = ST_DIV_WAIT;
        end else if (ch_r == CH_ALPHA) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (ch_r == CH_ALPHA) ? ST_EMIT : ST_DIV_GO;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        if (ch_r == CH_ALPHA) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ch_nxt        = ch_r;
    n_nxt         = n_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    slot_nxt      = slot_r;
    pix_nxt       = pix_r;
    alpha_tot_nxt = alpha_tot_r;
    red_tot_nxt   = red_tot_r;
    green_tot_nxt = green_tot_r;
    blue_tot_nxt  = blue_tot_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = oldest_e[ADDR_W-1:0];
    div_req.start = 1'b0;
    div_req.dividend = (ch_r == CH_ALPHA) ? DIV_W'(alpha_tot_r) : DIV_W'(tot_sel);
    div_req.divisor  = (ch_r == CH_ALPHA) ? ATOT_W'(n_r) : alpha_tot_r;
    res_we        = 1'b0;
    res_val       = div_rsp.quotient;

    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          n_nxt         = eff_size(cfg_data);
          fill_nxt      = '0;
          ptr_nxt       = '0;
          alpha_tot_nxt = '0;
          red_tot_nxt   = '0;
          green_tot_nxt = '0;
          blue_tot_nxt  = '0;
        end else if (in_fire) begin
          ram_wr_en = 1'b1;
          pix_nxt   = in_data;
          slot_nxt  = slot_in;
          ptr_nxt   = (slot_in == ADDR_W'(MAX_WINDOW - 1)) ? '0 : slot_in + 1'b1;
          ch_nxt    = CH_RED;
          if (in_data.row_start) begin
            alpha_tot_nxt = ATOT_W'(in_data.alpha);
            red_tot_nxt   = '0;
            green_tot_nxt = '0;
            blue_tot_nxt  = '0;
            fill_nxt      = N_W'(1);
          end else begin
            alpha_tot_nxt = alpha_tot_r + ATOT_W'(in_data.alpha);
            fill_nxt      = fill_r + 1'b1;
          end
        end
      end
      ST_ADD: begin
        case (ch_r)
          CH_RED:   red_tot_nxt   = mac_sum;
          CH_GREEN: green_tot_nxt = mac_sum;
          default:  blue_tot_nxt  = mac_sum;
        endcase
        ch_nxt = ch_r + 1'b1;
      end
      ST_CHECK: begin
        ch_nxt    = CH_RED;
        ram_rd_en = do_result;
      end
      ST_DIV_GO: begin
        if (alpha_tot_r == '0) begin
          res_we  = 1'b1;
          res_val = '0;
          ch_nxt  = ch_r + 1'b1;
        end else begin
          div_req.start = 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_we = 1'b1;
          ch_nxt = ch_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          ch_nxt        = CH_RED;
        end
      end
      ST_SUB: begin
        case (ch_r)
          CH_RED:   red_tot_nxt   = mac_diff;
          CH_GREEN: green_tot_nxt = mac_diff;
          CH_BLUE:  blue_tot_nxt  = mac_diff;
          default: begin
            alpha_tot_nxt = alpha_tot_r - ATOT_W'(old_a);
            fill_nxt      = nm1;
          end
        endcase
        ch_nxt = ch_r + 1'b1;
      end
      default: ;
    endcase

    if (res_we) begin
      case (ch_r)
        CH_RED:   res_nxt.out_red   = res_val;
        CH_GREEN: res_nxt.out_green = res_val;
        CH_BLUE:  res_nxt.out_blue  = res_val;
        default:  res_nxt.out_alpha = res_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= N_W'(1);
      fill_r      <= '0;
      ptr_r       <= '0;
      alpha_tot_r <= '0;
      red_tot_r   <= '0;
      green_tot_r <= '0;
      blue_tot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      alpha_tot_r <= alpha_tot_nxt;
      red_tot_r   <= red_tot_nxt;
      green_tot_r <= green_tot_nxt;
      blue_tot_r  <= blue_tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r       <= ch_nxt;
    slot_r     <= slot_nxt;
    pix_r      <= pix_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // window never holds a full N pixels between transactions
  a_fill_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (fill_r < n_r))
    else $error("fill count reached window size while idle");

  // weighted sums must be zero whenever the alpha sum is
  a_zero_alpha_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && alpha_tot_r == '0) |->
      (red_tot_r == '0 && green_tot_r == '0 && blue_tot_r == '0))
    else $error("colour sums nonzero with zero alpha sum");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_div_free_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO) |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
